>>> rtl/s5c_pkg.sv
package s5c_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_HOST  = 2'd1,
    ACT_RX    = 2'd2,
    ACT_LINK  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_BUSY        = 4'd0,
    ST_CONNECTED   = 4'd1,
    ST_EMPTY_HOST  = 4'd2,
    ST_METHOD_REJ  = 4'd3,
    ST_BAD_VERSION = 4'd4,
    ST_REFUSED     = 4'd5,
    ST_BAD_ATYP    = 4'd6,
    ST_LINK_FAILED = 4'd7,
    ST_UNEXPECTED  = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CMD_HELLO     = 3'd0,
    CMD_REQUEST   = 3'd1,
    CMD_HOST      = 3'd2,
    CMD_HOST_LAST = 3'd3,
    CMD_FINISH    = 3'd4
  } cmd_kind_e;

  localparam logic [7:0] SocksVer    = 8'h05;
  localparam logic [7:0] NMethods    = 8'h01;
  localparam logic [7:0] MethodNone  = 8'h00;
  localparam logic [7:0] CmdConnect  = 8'h01;
  localparam logic [7:0] Reserved    = 8'h00;
  localparam logic [7:0] ReplyOk     = 8'h00;
  localparam logic [7:0] AtypIpv4    = 8'h01;
  localparam logic [7:0] AtypDomain  = 8'h03;
  localparam logic [7:0] AtypIpv6    = 8'h04;
  localparam logic [7:0] MaxHostLen  = 8'd255;
  localparam logic [8:0] Ipv4Discard = 9'd6;
  localparam logic [8:0] Ipv6Discard = 9'd18;
  localparam logic [8:0] PortBytes   = 9'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  host_length;
    logic [15:0] dest_port;
    logic [7:0]  host_byte;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [3:0]  status;
    logic [7:0]  reply_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] port;
    status_e     status;
    logic [7:0]  code;
  } cmd_t;

endpackage

>>> rtl/s5c_chan_if.sv
interface s5c_chan_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/socks5_connect_client.sv
// An accepted item is first written into the command queue; its first result is then
// registered into the output register.
// Throughput: one item per cycle unless the queue is full; results leave one per cycle
// while out_o is ready, so an item with several results (hello 3, request 5, last host
// byte 3) holds the output; the queue between classifier and sequencer absorbs bursts.
// Reset: asynchronous, active low; phase idle, counters and queue empty, no result valid.
module socks5_connect_client #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  s5c_chan_if.sink   in_i,
  s5c_chan_if.source out_o
);
  import s5c_pkg::*;

  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  cmd_t            push_cmd, head_cmd;
  logic            push, pop, full, empty, front_idle;
  logic [CntW-1:0] fifo_count;

  s5c_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd),
    .idle_o (front_idle)
  );

  s5c_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty),
    .count_o (fifo_count)
  );

  s5c_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= CntW'(FIFO_DEPTH))
    else $error("command queue count out of range");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("push into a full command queue");

  a_link_fail_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.data.action == ACT_LINK) |=> front_idle)
    else $error("link failure did not return to idle");

  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.tx_valid) |-> (out_o.data.status == ST_BUSY))
    else $error("send byte carries a final status");

endmodule

>>> rtl/s5c_front.sv
module s5c_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  s5c_chan_if.sink       in_i,
  input  logic           full_i,
  output logic           push_o,
  output s5c_pkg::cmd_t  cmd_o,
  output logic           idle_o
);
  import s5c_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_METHOD  = 3'd1;
  localparam logic [2:0] PH_HOST    = 3'd2;
  localparam logic [2:0] PH_REPLY   = 3'd3;
  localparam logic [2:0] PH_DOMLEN  = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [8:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  host_left_q, host_left_d;
  logic [15:0] saved_port_q, saved_port_d;
  logic [7:0]  reply_version_q, reply_version_d;
  logic [7:0]  reply_status_q, reply_status_d;
  logic [1:0]  reply_index_q, reply_index_d;

  logic        accept;
  logic        cmd_valid;
  logic        fin;
  status_e     fin_status;
  logic [7:0]  fin_code;
  logic [8:0]  discard_left;
  in_item_t    item;

  assign item     = in_i.data;
  assign in_i.ready = !full_i;
  assign accept   = in_i.valid && !full_i;
  assign push_o   = accept && cmd_valid;
  assign idle_o   = (phase_q == PH_IDLE);
  assign discard_left = bytes_left_q - {8'd0, (bytes_left_q != 9'd0)};

  always_comb begin
    phase_d         = phase_q;
    bytes_left_d    = bytes_left_q;
    host_left_d     = host_left_q;
    saved_port_d    = saved_port_q;
    reply_version_d = reply_version_q;
    reply_status_d  = reply_status_q;
    reply_index_d   = reply_index_q;
    cmd_valid       = 1'b0;
    cmd_o           = '{kind: CMD_HELLO, data: 8'd0, port: 16'd0, status: ST_BUSY,
                        code: 8'd0};
    fin             = 1'b0;
    fin_status      = ST_BUSY;
    fin_code        = 8'd0;

    unique case (item.action)
      ACT_LINK: begin
        fin        = 1'b1;
        fin_status = ST_LINK_FAILED;
      end
      ACT_START: begin
        if (phase_q != PH_IDLE) begin
          fin        = 1'b1;
          fin_status = ST_UNEXPECTED;
        end else if (item.host_length == 8'd0 || item.host_length > MaxHostLen) begin
          fin        = 1'b1;
          fin_status = ST_EMPTY_HOST;
        end else begin
          host_left_d   = item.host_length;
          saved_port_d  = item.dest_port;
          reply_index_d = 2'd0;
          phase_d       = PH_METHOD;
          cmd_valid     = 1'b1;
          cmd_o.kind    = CMD_HELLO;
        end
      end
      ACT_HOST: begin
        if (phase_q != PH_HOST || host_left_q == 8'd0) begin
          fin        = 1'b1;
          fin_status = ST_UNEXPECTED;
        end else begin
          cmd_valid   = 1'b1;
          cmd_o.kind  = CMD_HOST;
          cmd_o.data  = item.host_byte;
          host_left_d = host_left_q - 8'd1;
          if (host_left_q == 8'd1) begin
            cmd_o.kind    = CMD_HOST_LAST;
            cmd_o.port    = saved_port_q;
            reply_index_d = 2'd0;
            phase_d       = PH_REPLY;
          end
        end
      end
      ACT_RX: begin
        case (phase_q)
          PH_METHOD: begin
            if (reply_index_q == 2'd0) begin
              reply_version_d = item.rx_byte;
              reply_index_d   = 2'd1;
            end else if (reply_version_q != SocksVer) begin
              fin        = 1'b1;
              fin_status = ST_METHOD_REJ;
              fin_code   = reply_version_q;
            end else if (item.rx_byte != MethodNone) begin
              fin        = 1'b1;
              fin_status = ST_METHOD_REJ;
              fin_code   = item.rx_byte;
            end else begin
              reply_index_d = 2'd0;
              phase_d       = PH_HOST;
              cmd_valid     = 1'b1;
              cmd_o.kind    = CMD_REQUEST;
              cmd_o.data    = host_left_q;
            end
          end
          PH_REPLY: begin
            if (reply_index_q == 2'd0) begin
              reply_version_d = item.rx_byte;
              reply_index_d   = 2'd1;
            end else if (reply_index_q == 2'd1) begin
              reply_status_d = item.rx_byte;
              reply_index_d  = 2'd2;
            end else if (reply_index_q == 2'd2) begin
              reply_index_d = 2'd3;
            end else if (reply_version_q != SocksVer) begin
              fin        = 1'b1;
              fin_status = ST_BAD_VERSION;
              fin_code   = reply_version_q;
            end else if (reply_status_q != ReplyOk) begin
              fin        = 1'b1;
              fin_status = ST_REFUSED;
              fin_code   = reply_status_q;
            end else if (item.rx_byte == AtypIpv4) begin
              bytes_left_d  = Ipv4Discard;
              reply_index_d = 2'd0;
              phase_d       = PH_DISCARD;
            end else if (item.rx_byte == AtypIpv6) begin
              bytes_left_d  = Ipv6Discard;
              reply_index_d = 2'd0;
              phase_d       = PH_DISCARD;
            end else if (item.rx_byte == AtypDomain) begin
              reply_index_d = 2'd0;
              phase_d       = PH_DOMLEN;
            end else begin
              fin        = 1'b1;
              fin_status = ST_BAD_ATYP;
              fin_code   = item.rx_byte;
            end
          end
          PH_DOMLEN: begin
            bytes_left_d = {1'b0, item.rx_byte} + PortBytes;
            phase_d      = PH_DISCARD;
          end
          PH_DISCARD: begin
            bytes_left_d = discard_left;
            if (discard_left == 9'd0) begin
              fin        = 1'b1;
              fin_status = ST_CONNECTED;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = ST_UNEXPECTED;
          end
        endcase
      end
    endcase

    if (fin) begin
      phase_d       = PH_IDLE;
      reply_index_d = 2'd0;
      bytes_left_d  = 9'd0;
      host_left_d   = 8'd0;
      cmd_valid     = 1'b1;
      cmd_o.kind    = CMD_FINISH;
      cmd_o.status  = fin_status;
      cmd_o.code    = fin_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      bytes_left_q    <= 9'd0;
      host_left_q     <= 8'd0;
      saved_port_q    <= 16'd0;
      reply_version_q <= 8'd0;
      reply_status_q  <= 8'd0;
      reply_index_q   <= 2'd0;
    end else if (accept) begin
      phase_q         <= phase_d;
      bytes_left_q    <= bytes_left_d;
      host_left_q     <= host_left_d;
      saved_port_q    <= saved_port_d;
      reply_version_q <= reply_version_d;
      reply_status_q  <= reply_status_d;
      reply_index_q   <= reply_index_d;
    end
  end

endmodule

>>> rtl/s5c_fifo.sv
module s5c_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  s5c_pkg::cmd_t                  data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output s5c_pkg::cmd_t                  data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);
  import s5c_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/s5c_back.sv
module s5c_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  s5c_pkg::cmd_t  cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  s5c_chan_if.source     out_o
);
  import s5c_pkg::*;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  last_idx;
  logic        fire;
  logic        is_last;

  always_comb begin
    case (cmd_i.kind)
      CMD_HELLO:     last_idx = 3'd2;
      CMD_REQUEST:   last_idx = 3'd4;
      CMD_HOST_LAST: last_idx = 3'd2;
      default:       last_idx = 3'd0;
    endcase
  end

  assign fire    = !empty_i && (!out_valid_q || out_o.ready);
  assign is_last = (idx_q == last_idx);
  assign pop_o   = fire && is_last;

  always_comb begin
    out_d            = '0;
    out_d.tx_valid   = 1'b1;
    out_d.status     = ST_BUSY;
    out_d.last       = is_last;
    case (cmd_i.kind)
      CMD_HELLO: begin
        case (idx_q)
          3'd0:    out_d.tx_byte = SocksVer;
          3'd1:    out_d.tx_byte = NMethods;
          default: out_d.tx_byte = MethodNone;
        endcase
      end
      CMD_REQUEST: begin
        case (idx_q)
          3'd0:    out_d.tx_byte = SocksVer;
          3'd1:    out_d.tx_byte = CmdConnect;
          3'd2:    out_d.tx_byte = Reserved;
          3'd3:    out_d.tx_byte = AtypDomain;
          default: out_d.tx_byte = cmd_i.data;
        endcase
      end
      CMD_HOST: out_d.tx_byte = cmd_i.data;
      CMD_HOST_LAST: begin
        case (idx_q)
          3'd0:    out_d.tx_byte = cmd_i.data;
          3'd1:    out_d.tx_byte = cmd_i.port[15:8];
          default: out_d.tx_byte = cmd_i.port[7:0];
        endcase
      end
      default: begin
        out_d.tx_valid   = 1'b0;
        out_d.status     = cmd_i.status;
        out_d.reply_code = cmd_i.code;
      end
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> verif/socks5_connect_client_test.sv
`timescale 1ns / 1ps

module socks5_connect_client_test;
  import s5c_pkg::*;

  class connect_scoreboard;
    typedef enum logic [2:0] {
      PH_IDLE, PH_METHOD, PH_HOST, PH_REPLY, PH_DOMLEN, PH_DISCARD
    } phase_e;

    phase_e      phase      = PH_IDLE;
    logic [8:0]  skip_left  = '0;
    logic [7:0]  host_left  = '0;
    logic [15:0] port_hold  = '0;
    logic [7:0]  held_ver   = '0;
    logic [7:0]  held_code  = '0;
    logic [1:0]  reply_pos  = '0;
    out_item_t   pending[$];
    out_item_t   burst[$];
    int          errors     = 0;

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void send_byte(logic [7:0] b);
      out_item_t r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      burst = {burst, r};
    endfunction

    function void conclude(status_e s, logic [7:0] code);
      out_item_t r;
      r = '0;
      r.status = s;
      r.reply_code = code;
      burst = {burst, r};
      phase = PH_IDLE;
      reply_pos = '0;
      skip_left = '0;
      host_left = '0;
    endfunction

    function void take_rx(logic [7:0] rx);
      case (phase)
        PH_METHOD: begin
          if (reply_pos == 2'd0) begin
            held_ver = rx;
            reply_pos = 2'd1;
          end else if (held_ver != SocksVer) begin
            conclude(ST_METHOD_REJ, held_ver);
          end else if (rx != MethodNone) begin
            conclude(ST_METHOD_REJ, rx);
          end else begin
            reply_pos = 2'd0;
            phase = PH_HOST;
            send_byte(SocksVer);
            send_byte(CmdConnect);
            send_byte(Reserved);
            send_byte(AtypDomain);
            send_byte(host_left);
          end
        end
        PH_REPLY: begin
          case (reply_pos)
            2'd0: begin
              held_ver = rx;
              reply_pos = 2'd1;
            end
            2'd1: begin
              held_code = rx;
              reply_pos = 2'd2;
            end
            2'd2: reply_pos = 2'd3;
            default: begin
              if (held_ver != SocksVer) begin
                conclude(ST_BAD_VERSION, held_ver);
              end else if (held_code != ReplyOk) begin
                conclude(ST_REFUSED, held_code);
              end else if (rx == AtypIpv4) begin
                skip_left = Ipv4Discard;
                reply_pos = 2'd0;
                phase = PH_DISCARD;
              end else if (rx == AtypIpv6) begin
                skip_left = Ipv6Discard;
                reply_pos = 2'd0;
                phase = PH_DISCARD;
              end else if (rx == AtypDomain) begin
                reply_pos = 2'd0;
                phase = PH_DOMLEN;
              end else begin
                conclude(ST_BAD_ATYP, rx);
              end
            end
          endcase
        end
        PH_DOMLEN: begin
          skip_left = {1'b0, rx} + PortBytes;
          phase = PH_DISCARD;
        end
        PH_DISCARD: begin
          if (skip_left != '0) skip_left = skip_left - 9'd1;
          if (skip_left == '0) conclude(ST_CONNECTED, 8'h00);
        end
        default: conclude(ST_UNEXPECTED, 8'h00);
      endcase
    endfunction

    function void note_item(in_item_t it);
      burst.delete();
      case (action_e'(it.action))
        ACT_LINK: conclude(ST_LINK_FAILED, 8'h00);
        ACT_START: begin
          if (phase != PH_IDLE) begin
            conclude(ST_UNEXPECTED, 8'h00);
          end else if (it.host_length == '0 || it.host_length > MaxHostLen) begin
            conclude(ST_EMPTY_HOST, 8'h00);
          end else begin
            host_left = it.host_length;
            port_hold = it.dest_port;
            reply_pos = 2'd0;
            phase = PH_METHOD;
            send_byte(SocksVer);
            send_byte(NMethods);
            send_byte(MethodNone);
          end
        end
        ACT_HOST: begin
          if (phase != PH_HOST || host_left == '0) begin
            conclude(ST_UNEXPECTED, 8'h00);
          end else begin
            send_byte(it.host_byte);
            host_left = host_left - 8'd1;
            if (host_left == '0) begin
              send_byte(port_hold[15:8]);
              send_byte(port_hold[7:0]);
              reply_pos = 2'd0;
              phase = PH_REPLY;
            end
          end
        end
        default: take_rx(it.rx_byte);
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      pending = {pending, burst};
    endfunction

    function void cmp(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_out(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: status %0d tx_byte 0x%0h",
               got.status, got.tx_byte);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp("tx_valid", want.tx_valid, got.tx_valid);
      cmp("tx_byte", want.tx_byte, got.tx_byte);
      cmp("status", want.status, got.status);
      cmp("reply_code", want.reply_code, got.reply_code);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  s5c_chan_if #(.payload_t(in_item_t))  in_ch ();
  s5c_chan_if #(.payload_t(out_item_t)) out_ch ();

  socks5_connect_client u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  connect_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int noise_pct = 0;
  int items_sent = 0;
  bit session_over;
  bit giant_done = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_out(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t noise_item();
    in_item_t r;
    r.action = 2'($urandom_range(3));
    r.host_length = 8'($urandom);
    r.dest_port = 16'($urandom);
    r.host_byte = 8'($urandom);
    r.rx_byte = 8'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] mostly(int pct, logic [7:0] v);
    return ($urandom_range(99) < pct) ? v : 8'($urandom);
  endfunction

  task automatic send_item(in_item_t it);
    if (items_sent < 157) begin
      send_idle_pct = 8;
      recv_idle_pct = 51;
    end else if (items_sent < 314) begin
      send_idle_pct = 51;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic drive(action_e a, logic [7:0] v8, logic [15:0] v16);
    in_item_t it;
    it = noise_item();
    it.action = a;
    case (a)
      ACT_START: begin
        it.host_length = v8;
        it.dest_port = v16;
      end
      ACT_HOST: it.host_byte = v8;
      ACT_RX:   it.rx_byte = v8;
      default: ;
    endcase
    send_item(it);
  endtask

  task automatic step(action_e a, logic [7:0] v8, logic [15:0] v16);
    if (session_over) return;
    if ($urandom_range(99) < noise_pct) send_item(noise_item());
    else drive(a, v8, v16);
    if (sb.idle()) session_over = 1'b1;
  endtask

  task automatic run_session(int hlen, int dlen);
    logic [7:0] atyp;
    int r;
    int nskip;
    session_over = 1'b0;
    step(ACT_START, 8'(hlen), 16'($urandom));
    step(ACT_RX, mostly(90, SocksVer), '0);
    step(ACT_RX, mostly(90, MethodNone), '0);
    for (int i = 0; i < hlen; i++) step(ACT_HOST, 8'($urandom), '0);
    step(ACT_RX, mostly(88, SocksVer), '0);
    step(ACT_RX, mostly(85, ReplyOk), '0);
    step(ACT_RX, 8'($urandom), '0);
    r = $urandom_range(99);
    atyp = (r < 30) ? AtypIpv4 : (r < 55) ? AtypIpv6 : (r < 90) ? AtypDomain : 8'($urandom);
    step(ACT_RX, atyp, '0);
    if (atyp == AtypIpv4) begin
      nskip = 6;
    end else if (atyp == AtypIpv6) begin
      nskip = 18;
    end else begin
      nskip = dlen + 2;
      if (atyp == AtypDomain) step(ACT_RX, 8'(dlen), '0);
    end
    for (int i = 0; i < nskip; i++) step(ACT_RX, 8'($urandom), '0);
    if (!sb.idle() && $urandom_range(99) < 70) drive(ACT_LINK, 8'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive(ACT_START, 8'h00, 16'h0000);
    drive(ACT_LINK, 8'hFF, 16'hFFFF);
    drive(ACT_HOST, 8'hFF, 16'h0000);
    drive(ACT_RX, 8'h00, 16'h0000);

    drive(ACT_START, 8'h01, 16'hFFFF);
    drive(ACT_RX, SocksVer, '0);
    drive(ACT_RX, MethodNone, '0);
    drive(ACT_HOST, 8'h00, '0);
    drive(ACT_RX, SocksVer, '0);
    drive(ACT_RX, ReplyOk, '0);
    drive(ACT_RX, 8'hFF, '0);
    drive(ACT_RX, AtypDomain, '0);
    drive(ACT_RX, 8'h00, '0);
    drive(ACT_RX, 8'hFF, '0);
    drive(ACT_RX, 8'h00, '0);

    drive(ACT_START, 8'h02, 16'h0000);
    drive(ACT_RX, 8'h04, '0);
    drive(ACT_RX, MethodNone, '0);

    drive(ACT_START, 8'h01, 16'h1234);
    drive(ACT_RX, SocksVer, '0);
    drive(ACT_RX, 8'hFF, '0);

    drive(ACT_START, 8'h01, 16'h8001);
    drive(ACT_START, 8'h03, 16'h0000);

    drive(ACT_START, 8'h02, 16'h00FF);
    drive(ACT_RX, SocksVer, '0);
    drive(ACT_RX, MethodNone, '0);
    drive(ACT_RX, SocksVer, '0);

    noise_pct = 1;
    while (items_sent < 470) begin
      if (!giant_done && items_sent >= 100) begin
        noise_pct = 0;
        run_session(255, 3);
        if (!sb.idle()) drive(ACT_LINK, '0, '0);
        noise_pct = 1;
        giant_done = 1'b1;
      end else begin
        run_session(($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6), $urandom_range(0, 6));
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS socks5_connect_client");
    end else begin
      $display("FAIL socks5_connect_client");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL socks5_connect_client");
    $finish;
  end

endmodule
